FILE: rtl/firmware_download_frame_receiver_macros.svh
// assertion macros for the download frame receiver
`ifndef FIRMWARE_DOWNLOAD_FRAME_RECEIVER_MACROS_SVH
`define FIRMWARE_DOWNLOAD_FRAME_RECEIVER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FDFR_ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FDFR_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FDFR_ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons, msg)
`define FDFR_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg)
`endif

`endif

FILE: rtl/fdfr_pkg.sv
// types and constants of the download frame receiver
package fdfr_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MAXP_W     = 13;
  localparam logic [MAXP_W-1:0] MAXP_RESET = 13'd8;

  // length byte plus overhead needs one extra bit
  localparam int unsigned LEN_EXT_W = 9;

  // frame layout
  localparam int unsigned POS_HEAD     = 0;
  localparam int unsigned POS_KIND     = 1;
  localparam int unsigned POS_INDEX    = 2;
  localparam int unsigned POS_LEN      = 3;
  localparam int unsigned POS_STATION  = 4;
  localparam int unsigned POS_PAYLOAD  = 4;
  localparam int unsigned POS_SIZE_HI  = 5;
  localparam int unsigned POS_SIZE_LO  = 8;
  localparam int unsigned MIN_FRAME_BYTES      = 6;
  localparam int unsigned MIN_SIZE_FRAME_BYTES = 11;
  localparam int unsigned LEN_OVERHEAD         = 6;

  // frame kind and index codes
  localparam logic [7:0] KIND_SIZE  = 8'h01;
  localparam logic [7:0] KIND_MORE  = 8'h02;
  localparam logic [7:0] KIND_DONE  = 8'h03;
  localparam logic [7:0] INDEX_SIZE = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATION   = 3'd0,
    CFG_HEAD      = 3'd1,
    CFG_END       = 3'd2,
    CFG_OFFSET    = 3'd3,
    CFG_MAX_PAGES = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_HEAD     = 4'd1,
    ST_END      = 4'd2,
    ST_CHECKSUM = 4'd3,
    ST_KIND     = 4'd4,
    ST_INDEX    = 4'd5,
    ST_STATION  = 4'd6,
    ST_OVERLOAD = 4'd7,
    ST_LENGTH   = 4'd8
  } status_t;

  typedef enum logic {
    IN_BYTE  = 1'b0,
    IN_ABORT = 1'b1
  } in_kind_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_SCAN  = 3'd1,
    S_EVAL  = 3'd2,
    S_PAY   = 3'd3,
    S_PWAIT = 3'd4
  } state_t;

  typedef struct packed {
    in_kind_t   kind;
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  frame_kind;
    logic [7:0]  frame_index;
    logic [31:0] file_size;
    logic [7:0]  payload_length;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        session_done;
    logic        last;
  } out_item_t;

endpackage

FILE: rtl/fdfr_ram.sv
// generic single-port-write, single-port-read ram with registered read
module fdfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/firmware_download_frame_receiver.sv
// download frame receiver: stores frame bytes, checks the frame, emits payload
// a byte without end mark is stored while idle; a frame of n bytes is then scanned from
// the frame ram one byte a cycle through a shared checksum adder: a frame gives a single
// result beat, or for a data frame with payload one beat per payload byte
// payload bytes leave one at a time (ram read, then output register, held while stalled)
// rst_n is synchronous; it clears control state, configuration and output valid, not the frame ram
`include "firmware_download_frame_receiver_macros.svh"

module firmware_download_frame_receiver #(
  parameter int unsigned FRAME_BYTES = 64,
  parameter int unsigned PAGE_BYTES  = 131072
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input beats
  input  logic                             in_valid,
  output logic                             in_stall,
  input  fdfr_pkg::in_item_t               in_item,
  // result beats
  output logic                             out_valid,
  input  logic                             out_stall,
  output fdfr_pkg::out_item_t              out_item,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fdfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fdfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned AW    = $clog2(FRAME_BYTES);
  localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int unsigned PB_W  = $clog2(PAGE_BYTES + 1);
  localparam int unsigned LIM_W = fdfr_pkg::MAXP_W + PB_W;
  localparam int unsigned CMP_W = (LIM_W > 32) ? LIM_W : 32;
  localparam int unsigned LXW   = fdfr_pkg::LEN_EXT_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_BYTES);

  fdfr_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic [7:0]                  station_r;
  logic [7:0]                  head_r;
  logic [7:0]                  endb_r;
  logic [7:0]                  off_r;
  logic [fdfr_pkg::MAXP_W-1:0] maxp_r;
  logic [LIM_W-1:0]            limit_r;

  // session and frame state
  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  logic             phase_r;
  logic [7:0]       req_r;

  // scan and captured frame fields
  logic [CNT_W-1:0] scan_r;
  logic             rvalid_r;
  logic [CNT_W-1:0] ridx_r;
  logic [7:0]       b0_r;
  logic [7:0]       fk_r;
  logic [7:0]       fi_r;
  logic [7:0]       len_r;
  logic [7:0]       stn_r;
  logic [31:0]      size_r;
  logic [7:0]       chk_r;
  logic [7:0]       tail_r;
  logic [7:0]       sum_r;
  logic [CNT_W-1:0] pay_r;

  // output register
  logic                out_valid_r;
  fdfr_pkg::out_item_t out_item_r;
  fdfr_pkg::out_item_t out_next;
  logic                out_load;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // handshake terms
  logic in_acc, byte_acc, abort_acc, eof_acc, room, slot_free;
  logic scan_more, last_pay, finish, eval_go;
  logic [CNT_W-1:0] n_m1, n_m2;

  // verdict
  fdfr_pkg::status_t frame_st, st_eval;
  logic       ok_size, ok_data, single_res;
  logic [7:0] csum_exp;

  assign in_acc    = in_valid && !in_stall;
  assign byte_acc  = in_acc && (in_item.kind == fdfr_pkg::IN_BYTE);
  assign abort_acc = in_acc && (in_item.kind == fdfr_pkg::IN_ABORT);
  assign eof_acc   = byte_acc && in_item.end_of_frame;
  assign room      = cnt_r < FULL_CNT;
  assign slot_free = !out_valid_r || !out_stall;
  assign scan_more = scan_r < cnt_r;
  assign n_m1      = cnt_r - CNT_W'(1);
  assign n_m2      = cnt_r - CNT_W'(2);
  assign last_pay  = LXW'(pay_r) ==
                     (LXW'(len_r) + LXW'(fdfr_pkg::POS_PAYLOAD) - LXW'(1));

  // frame store
  fdfr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_item.rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= '0;
      head_r    <= '0;
      endb_r    <= '0;
      off_r     <= '0;
      maxp_r    <= fdfr_pkg::MAXP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (fdfr_pkg::cfg_reg_t'(cfg_index))
        fdfr_pkg::CFG_STATION:   station_r <= cfg_data[7:0];
        fdfr_pkg::CFG_HEAD:      head_r    <= cfg_data[7:0];
        fdfr_pkg::CFG_END:       endb_r    <= cfg_data[7:0];
        fdfr_pkg::CFG_OFFSET:    off_r     <= cfg_data[7:0];
        fdfr_pkg::CFG_MAX_PAGES: maxp_r    <= cfg_data[fdfr_pkg::MAXP_W-1:0];
        default: ;
      endcase
    end
  end

  // byte limit of the file: pages times page size
  always_ff @(posedge clk) begin
    limit_r <= LIM_W'(maxp_r) * LIM_W'(PAGE_BYTES);
  end

  // frame-level checks on the captured bytes
  assign csum_exp = 8'(~sum_r + off_r);

  always_comb begin
    if (ovf_r || (cnt_r < CNT_W'(fdfr_pkg::MIN_FRAME_BYTES))) begin
      frame_st = fdfr_pkg::ST_LENGTH;
    end else if (b0_r != head_r) begin
      frame_st = fdfr_pkg::ST_HEAD;
    end else if (tail_r != endb_r) begin
      frame_st = fdfr_pkg::ST_END;
    end else if (chk_r != csum_exp) begin
      frame_st = fdfr_pkg::ST_CHECKSUM;
    end else begin
      frame_st = fdfr_pkg::ST_OK;
    end
  end

  // phase checks: size frame or data frame
  always_comb begin
    st_eval = frame_st;
    ok_size = 1'b0;
    ok_data = 1'b0;
    if (frame_st == fdfr_pkg::ST_OK) begin
      if (!phase_r) begin
        if (fk_r != fdfr_pkg::KIND_SIZE) begin
          st_eval = fdfr_pkg::ST_KIND;
        end else if (fi_r != fdfr_pkg::INDEX_SIZE) begin
          st_eval = fdfr_pkg::ST_INDEX;
        end else if (cnt_r < CNT_W'(fdfr_pkg::MIN_SIZE_FRAME_BYTES)) begin
          st_eval = fdfr_pkg::ST_LENGTH;
        end else if (stn_r != station_r) begin
          st_eval = fdfr_pkg::ST_STATION;
        end else if (CMP_W'(size_r) > CMP_W'(limit_r)) begin
          st_eval = fdfr_pkg::ST_OVERLOAD;
        end else begin
          ok_size = 1'b1;
        end
      end else begin
        if (fi_r != 8'(req_r + 8'd1)) begin
          st_eval = fdfr_pkg::ST_INDEX;
        end else if (fk_r != fdfr_pkg::KIND_MORE && fk_r != fdfr_pkg::KIND_DONE) begin
          st_eval = fdfr_pkg::ST_KIND;
        end else if ((LXW'(len_r) + LXW'(fdfr_pkg::LEN_OVERHEAD)) > LXW'(cnt_r)) begin
          st_eval = fdfr_pkg::ST_LENGTH;
        end else begin
          ok_data = 1'b1;
        end
      end
    end
  end

  assign single_res = !(ok_data && (len_r != 8'd0));

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fdfr_pkg::S_IDLE: begin
        if (eof_acc) state_nxt = fdfr_pkg::S_SCAN;
      end
      fdfr_pkg::S_SCAN: begin
        if (!scan_more) state_nxt = fdfr_pkg::S_EVAL;
      end
      fdfr_pkg::S_EVAL: begin
        if (!single_res) begin
          state_nxt = fdfr_pkg::S_PAY;
        end else if (slot_free) begin
          state_nxt = fdfr_pkg::S_IDLE;
        end
      end
      fdfr_pkg::S_PAY: begin
        state_nxt = fdfr_pkg::S_PWAIT;
      end
      fdfr_pkg::S_PWAIT: begin
        if (slot_free) begin
          state_nxt = last_pay ? fdfr_pkg::S_IDLE : fdfr_pkg::S_PAY;
        end
      end
      default: state_nxt = fdfr_pkg::S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_re    = 1'b0;
    ram_raddr = scan_r[AW-1:0];
    out_load  = 1'b0;
    finish    = 1'b0;
    eval_go   = 1'b0;
    out_next  = '{
      status:         st_eval,
      frame_kind:     fk_r,
      frame_index:    fi_r,
      file_size:      ok_size ? size_r : 32'd0,
      payload_length: ok_data ? len_r : 8'd0,
      payload_byte:   8'd0,
      byte_valid:     1'b0,
      session_done:   ok_data && (fk_r == fdfr_pkg::KIND_DONE),
      last:           1'b1
    };
    case (state_r)
      fdfr_pkg::S_IDLE: begin
        in_stall = 1'b0;
        ram_we   = byte_acc && room;
      end
      fdfr_pkg::S_SCAN: begin
        ram_re = scan_more;
      end
      fdfr_pkg::S_EVAL: begin
        eval_go  = !single_res || slot_free;
        out_load = single_res && slot_free;
        finish   = single_res && slot_free;
      end
      fdfr_pkg::S_PAY: begin
        ram_re    = 1'b1;
        ram_raddr = pay_r[AW-1:0];
      end
      fdfr_pkg::S_PWAIT: begin
        out_load = slot_free;
        finish   = slot_free && last_pay;
        out_next = '{
          status:         fdfr_pkg::ST_OK,
          frame_kind:     fk_r,
          frame_index:    fi_r,
          file_size:      32'd0,
          payload_length: len_r,
          payload_byte:   ram_rdata,
          byte_valid:     1'b1,
          session_done:   fk_r == fdfr_pkg::KIND_DONE,
          last:           last_pay
        };
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fdfr_pkg::S_IDLE;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      phase_r  <= 1'b0;
      req_r    <= '0;
      rvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rvalid_r <= (state_r == fdfr_pkg::S_SCAN) && scan_more;

      // byte count and overflow
      if (abort_acc || finish) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else if (byte_acc && room) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (byte_acc) begin
        ovf_r <= 1'b1;
      end

      // session phase and expected index
      if (abort_acc) begin
        phase_r <= 1'b0;
        req_r   <= '0;
      end else if (eval_go) begin
        if (ok_size) begin
          phase_r <= 1'b1;
          req_r   <= '0;
        end else if (ok_data && (fk_r != fdfr_pkg::KIND_DONE)) begin
          req_r <= 8'(req_r + 8'd1);
        end else begin
          phase_r <= 1'b0;
          req_r   <= '0;
        end
      end
    end
  end

  // scan address and read pipeline index
  always_ff @(posedge clk) begin
    if (eof_acc) begin
      scan_r <= '0;
    end else if ((state_r == fdfr_pkg::S_SCAN) && scan_more) begin
      scan_r <= scan_r + CNT_W'(1);
    end
    ridx_r <= scan_r;
  end

  // capture header, trailer and running sum from the scanned bytes
  always_ff @(posedge clk) begin
    if (eof_acc) begin
      sum_r <= '0;
      fk_r  <= '0;
      fi_r  <= '0;
    end else if (rvalid_r) begin
      if (ridx_r == CNT_W'(fdfr_pkg::POS_HEAD))    b0_r  <= ram_rdata;
      if (ridx_r == CNT_W'(fdfr_pkg::POS_KIND))    fk_r  <= ram_rdata;
      if (ridx_r == CNT_W'(fdfr_pkg::POS_INDEX))   fi_r  <= ram_rdata;
      if (ridx_r == CNT_W'(fdfr_pkg::POS_LEN))     len_r <= ram_rdata;
      if (ridx_r == CNT_W'(fdfr_pkg::POS_STATION)) stn_r <= ram_rdata;
      if (ridx_r >= CNT_W'(fdfr_pkg::POS_SIZE_HI) &&
          ridx_r <= CNT_W'(fdfr_pkg::POS_SIZE_LO)) begin
        size_r <= {size_r[23:0], ram_rdata};
      end
      if (ridx_r == n_m2) chk_r  <= ram_rdata;
      if (ridx_r == n_m1) tail_r <= ram_rdata;
      if (ridx_r >= CNT_W'(fdfr_pkg::POS_KIND) && ridx_r < n_m2) begin
        sum_r <= 8'(sum_r + ram_rdata);
      end
    end
  end

  // payload read address
  always_ff @(posedge clk) begin
    if (eval_go) begin
      pay_r <= CNT_W'(fdfr_pkg::POS_PAYLOAD);
    end else if ((state_r == fdfr_pkg::S_PWAIT) && slot_free) begin
      pay_r <= pay_r + CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= out_next;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  `FDFR_ASSERT_IMPLIES(a_ovf_full, clk, rst_n, ovf_r, cnt_r == FULL_CNT, "overflow with store not full")
  `FDFR_ASSERT_IMPLIES(a_pay_in_frame, clk, rst_n, state_r == fdfr_pkg::S_PAY, pay_r < cnt_r, "payload read beyond frame")
  `FDFR_ASSERT_NEXT(a_abort_clears, clk, rst_n, abort_acc, !phase_r && cnt_r == '0 && req_r == '0, "abort left session state")

endmodule
